/* rtl/met_recoil_shift_defines.svh */
// Assertion macros used by the block's top-level RTL file.
`ifndef MET_RECOIL_SHIFT_DEFINES_SVH
`define MET_RECOIL_SHIFT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/mrs_pkg.sv */
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, constants and helper functions of the recoil shift block.
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int MAX_STEPS        = 24;
	localparam int LANES            = 4;
	localparam int MAG_W            = 16;
	localparam int ANG_W            = 16;
	localparam int XY_W             = 36;
	localparam int Z_W              = 34;
	localparam int RES_W            = 20;

	localparam logic [1:0] MET_RESP_UP    = 2'd0;
	localparam logic [1:0] MET_RESP_DOWN  = 2'd1;
	localparam logic [1:0] MET_RESOL_UP   = 2'd2;
	localparam logic [1:0] MET_RESOL_DOWN = 2'd3;

	localparam logic [15:0] SCALE_RESET = 16'd6554;

	localparam logic ADDR_SCALE = 1'b0;
	localparam logic ADDR_MODE  = 1'b1;

	typedef struct packed {
		logic [MAG_W-1:0] lepton_mag;
		logic signed [ANG_W-1:0] lepton_angle;
		logic [MAG_W-1:0] met_mag;
		logic signed [ANG_W-1:0] met_angle;
		logic [MAG_W-1:0] true_met_mag;
		logic signed [ANG_W-1:0] true_met_angle;
		logic true_lepton_present;
		logic [MAG_W-1:0] true_lepton_mag;
		logic signed [ANG_W-1:0] true_lepton_angle;
	} mrs_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] shifted_met_x;
		logic signed [RES_W-1:0] shifted_met_y;
	} mrs_out_t;

	typedef struct packed {
		logic [15:0] scale;
		logic        resol;
		logic        minus;
	} mrs_cfg_t;

	typedef logic [31:0] atan_tab_t [MAX_STEPS];
	localparam atan_tab_t ATAN_TAB = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Arctangent of 2^-i rounded to the angle grid, in 2^31 = pi units.
	function automatic logic signed [Z_W-1:0] atan_grid(input int i, input int abits);
		logic [32:0] a;
		int sh;
		begin
			sh = 32 - abits;
			a = {1'b0, ATAN_TAB[i]} + (33'd1 << (sh - 1));
			a = (a >> sh) << sh;
			atan_grid = Z_W'(signed'({1'b0, a}));
		end
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] w;
		begin
			r = '0;
			w = v;
			b = 64'd1 << 62;
			while (b > w) b = b >> 2;
			while (b != 0) begin
				if (w >= r + b) begin
					w = w - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			isqrt64 = r;
		end
	endfunction

	// Squared CORDIC gain in Q60, evaluated at elaboration.
	function automatic logic [63:0] gain_prod(input int steps);
		logic [63:0] p;
		begin
			p = 64'd1 << 60;
			for (int i = 0; i < steps && i < MAX_STEPS; i++) p = p + (p >> (2 * i));
			gain_prod = p;
		end
	endfunction

endpackage

/* rtl/met_recoil_shift.sv */
// ----------------------------------------------------------------------------
// met_recoil_shift
// Shifts the missing transverse momentum through the hadronic recoil.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// input     start / busy        data_in (mrs_in_t)
// output    done                data_out (mrs_out_t)
// config    APB psel/penable    pwdata, prdata
//
// One transaction enters every cycle; busy is always low.
// Each result passes one register for gain and quadrant, one per CORDIC
// step and three for merge before it appears on data_out.
// Reset sets the config registers to their defaults and clears the valid pipeline; no clearing pass.
// The receiver cannot stall, so results are never held.
module met_recoil_shift #(
	parameter int ANGLE_BITS   = mrs_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = mrs_pkg::CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mrs_pkg::mrs_in_t data_in,
	output logic done,
	output mrs_pkg::mrs_out_t data_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:2] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import mrs_pkg::*;
	`include "met_recoil_shift_defines.svh"

	localparam int LAT = CORDIC_STEPS + 4;

	logic [15:0] scale_q;
	logic [1:0]  mode_q;
	logic [LAT-1:0] vld_q;
	logic [CORDIC_STEPS:0] pres_q;
	logic signed [XY_W-1:0] vx [LANES];
	logic signed [XY_W-1:0] vy [LANES];
	logic [MAG_W-1:0] mags [LANES];
	logic signed [ANG_W-1:0] angs [LANES];
	mrs_cfg_t cfg;
	logic wr;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			mode_q <= MET_RESP_UP;
		end else if (wr) begin
			case (paddr[2])
				ADDR_SCALE: scale_q <= pwdata[15:0];
				ADDR_MODE: mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == ADDR_MODE) ? {30'd0, mode_q} : {16'd0, scale_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		pres_q <= {pres_q[CORDIC_STEPS-1:0], data_in.true_lepton_present};
	end

	assign mags[0] = data_in.lepton_mag;
	assign angs[0] = data_in.lepton_angle;
	assign mags[1] = data_in.met_mag;
	assign angs[1] = data_in.met_angle;
	assign mags[2] = data_in.true_met_mag;
	assign angs[2] = data_in.true_met_angle;
	assign mags[3] = data_in.true_lepton_mag;
	assign angs[3] = data_in.true_lepton_angle;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		mrs_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane (
			.clk(clk), .mag(mags[l]), .angle(angs[l]), .x(vx[l]), .y(vy[l])
		);
	end

	assign cfg.scale = scale_q;
	assign cfg.resol = (mode_q == MET_RESOL_UP) || (mode_q == MET_RESOL_DOWN);
	assign cfg.minus = (mode_q == MET_RESP_DOWN) || (mode_q == MET_RESOL_DOWN);

	mrs_merge u_merge (
		.clk(clk), .cfg(cfg), .use_true(pres_q[CORDIC_STEPS]),
		.lx(vx[0]), .ly(vy[0]), .mx(vx[1]), .my(vy[1]),
		.gx(vx[2]), .gy(vy[2]), .tx(vx[3]), .ty(vy[3]),
		.result(data_out)
	);

	assign done = vld_q[LAT-1];

	`MRS_ASSERT_NEXT(a_start_done_chain, clk, arst_n, start, vld_q[0])
	`MRS_ASSERT_NEXT(a_done_follows, clk, arst_n, vld_q[LAT-2], done)
	`MRS_ASSERT_IMP(a_never_busy, clk, arst_n, start, !busy)

endmodule

/* rtl/mrs_cordic_lane.sv */
// ----------------------------------------------------------------------------
// mrs_cordic_lane
// Pipelined rotation-mode CORDIC that turns one polar vector into x and y.
// ----------------------------------------------------------------------------
module mrs_cordic_lane #(
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic [mrs_pkg::MAG_W-1:0] mag,
	input  logic signed [mrs_pkg::ANG_W-1:0] angle,
	output logic signed [mrs_pkg::XY_W-1:0] x,
	output logic signed [mrs_pkg::XY_W-1:0] y
);
	import mrs_pkg::*;

	localparam logic [63:0] GAIN_P = gain_prod(CORDIC_STEPS);
	localparam logic [63:0] GAIN_Q = (64'd1 << 60) / isqrt64(GAIN_P);
	localparam logic [31:0] GAIN = GAIN_Q[31:0];
	localparam logic [31:0] AMASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(64'sd1 << 30);
	localparam logic signed [Z_W-1:0] PI = Z_W'(64'sd1 << 31);

	logic signed [XY_W-1:0] x_s1;
	logic signed [Z_W-1:0]  z_s1;
	logic signed [XY_W-1:0] xs [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] ys [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  zs [CORDIC_STEPS+1];
	logic [31:0] za;
	logic signed [Z_W-1:0] z0;
	logic [48:0] prod;

	assign za = {angle, 16'd0} & AMASK;
	assign z0 = Z_W'(signed'(za));
	assign prod = {17'd0, mag} * {17'd0, GAIN} + 49'(1 << 13);

	always_ff @(posedge clk) begin
		if (z0 > HALF_PI || z0 < -HALF_PI) begin
			z_s1 <= (z0 > 0) ? z0 - PI : z0 + PI;
			x_s1 <= -XY_W'(signed'({1'b0, prod[48:14]}));
		end else begin
			z_s1 <= z0;
			x_s1 <= XY_W'(signed'({1'b0, prod[48:14]}));
		end
	end

	assign xs[0] = x_s1;
	assign ys[0] = '0;
	assign zs[0] = z_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [Z_W-1:0] A = atan_grid(i, ANGLE_BITS);
		logic signed [XY_W-1:0] x_q;
		logic signed [XY_W-1:0] y_q;
		logic signed [Z_W-1:0]  z_q;
		always_ff @(posedge clk) begin
			if (!zs[i][Z_W-1]) begin
				x_q <= xs[i] - (ys[i] >>> i);
				y_q <= ys[i] + (xs[i] >>> i);
				z_q <= zs[i] - A;
			end else begin
				x_q <= xs[i] + (ys[i] >>> i);
				y_q <= ys[i] - (xs[i] >>> i);
				z_q <= zs[i] + A;
			end
		end
		assign xs[i+1] = x_q;
		assign ys[i+1] = y_q;
		assign zs[i+1] = z_q;
	end

	assign x = xs[CORDIC_STEPS];
	assign y = ys[CORDIC_STEPS];

endmodule

/* rtl/mrs_merge.sv */
// ----------------------------------------------------------------------------
// mrs_merge
// Combines the lane vectors, applies the shift, rounds and saturates the result.
// ----------------------------------------------------------------------------
module mrs_merge (
	input  logic clk,
	input  mrs_pkg::mrs_cfg_t cfg,
	input  logic use_true,
	input  logic signed [mrs_pkg::XY_W-1:0] lx,
	input  logic signed [mrs_pkg::XY_W-1:0] ly,
	input  logic signed [mrs_pkg::XY_W-1:0] mx,
	input  logic signed [mrs_pkg::XY_W-1:0] my,
	input  logic signed [mrs_pkg::XY_W-1:0] gx,
	input  logic signed [mrs_pkg::XY_W-1:0] gy,
	input  logic signed [mrs_pkg::XY_W-1:0] tx,
	input  logic signed [mrs_pkg::XY_W-1:0] ty,
	output mrs_pkg::mrs_out_t result
);
	import mrs_pkg::*;

	localparam int D_W = XY_W + 3;
	localparam int P_W = D_W + 18;

	logic signed [D_W-1:0] dx_s1, dy_s1, mx_s1, my_s1;
	logic signed [P_W-1:0] px_s2, py_s2;
	logic signed [P_W-1:0] mx_s2, my_s2;
	logic signed [XY_W-1:0] tx_sel, ty_sel;
	logic signed [D_W-1:0] dx, dy;

	assign tx_sel = use_true ? tx : lx;
	assign ty_sel = use_true ? ty : ly;
	assign dx = cfg.resol ? D_W'(mx) + D_W'(lx) - D_W'(gx) - D_W'(tx_sel) : D_W'(mx) + D_W'(lx);
	assign dy = cfg.resol ? D_W'(my) + D_W'(ly) - D_W'(gy) - D_W'(ty_sel) : D_W'(my) + D_W'(ly);

	always_ff @(posedge clk) begin
		dx_s1 <= dx;
		dy_s1 <= dy;
		mx_s1 <= D_W'(mx);
		my_s1 <= D_W'(my);
	end

	always_ff @(posedge clk) begin
		px_s2 <= cfg.minus ? -(P_W'(dx_s1) * P_W'(signed'({1'b0, cfg.scale})))
		                   : P_W'(dx_s1) * P_W'(signed'({1'b0, cfg.scale}));
		py_s2 <= cfg.minus ? -(P_W'(dy_s1) * P_W'(signed'({1'b0, cfg.scale})))
		                   : P_W'(dy_s1) * P_W'(signed'({1'b0, cfg.scale}));
		mx_s2 <= P_W'(mx_s1) <<< 16;
		my_s2 <= P_W'(my_s1) <<< 16;
	end

	function automatic logic signed [RES_W-1:0] fin(input logic signed [P_W-1:0] m,
		input logic signed [P_W-1:0] p);
		logic signed [P_W:0] t;
		logic signed [P_W-32:0] r;
		begin
			t = (P_W+1)'(m) + (P_W+1)'(p) + (P_W+1)'(64'sd1 << 31);
			r = t[P_W:32];
			if (r > (P_W-31)'(524287)) fin = RES_W'(524287);
			else if (r < -(P_W-31)'(524288)) fin = RES_W'(-524288);
			else fin = r[RES_W-1:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		result.shifted_met_x <= fin(mx_s2, px_s2);
		result.shifted_met_y <= fin(my_s2, py_s2);
	end

endmodule

/* sim/tb_met_recoil_shift.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_met_recoil_shift
// Self-checking bench for the recoil shift block. Events are driven through
// the start/busy port with random gaps, except in one steady phase; the shift
// settings change over APB between phases. An in-bench model turns the polar
// vectors into x and y, applies the chosen shift and checks results in order.
// ----------------------------------------------------------------------------
module tb_met_recoil_shift;
	import mrs_pkg::*;

	class met_shift_board;
		logic [15:0] scale;
		logic [1:0] mode;
		longint gain;
		mrs_out_t pending[$];
		int errors;
		int events;
		int results;

		function new();
			longint unsigned p, v, r, b;
			p = 64'd1 << 60;
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) p = p + (p >> (2 * i));
			v = p;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			gain = longint'((64'd1 << 60) / r);
			scale = SCALE_RESET;
			mode = MET_RESP_UP;
		endfunction

		function void to_xy(input logic [15:0] mag, input logic [15:0] ang,
				output longint x, output longint y);
			logic signed [31:0] za;
			longint z, a, dx, dy;
			za = {ang, 16'b0};
			z = za;
			x = (longint'(mag) * gain + (longint'(1) << 13)) >>> 14;
			y = 0;
			if (z > (longint'(1) << 30) || z < -(longint'(1) << 30)) begin
				z = (z > 0) ? z - (longint'(1) << 31) : z + (longint'(1) << 31);
				x = -x;
			end
			for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
				a = ((longint'({32'b0, ATAN_TAB[i]}) + (longint'(1) << 15)) >> 16) << 16;
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - a;
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + a;
				end
			end
		endfunction

		function logic signed [19:0] settle(input longint m, input longint d, input bit minus);
			longint t, r;
			t = m * 65536 + (minus ? -(d * longint'(scale)) : d * longint'(scale));
			r = (t + (longint'(1) << 31)) >>> 32;
			if (r > 524287) r = 524287;
			if (r < -524288) r = -524288;
			return r[19:0];
		endfunction

		function void note(input mrs_in_t t);
			longint lx, ly, mx, my, gx, gy, tx, ty, dx, dy;
			mrs_out_t e;
			bit minus;
			to_xy(t.lepton_mag, t.lepton_angle, lx, ly);
			to_xy(t.met_mag, t.met_angle, mx, my);
			to_xy(t.true_met_mag, t.true_met_angle, gx, gy);
			if (t.true_lepton_present) begin
				to_xy(t.true_lepton_mag, t.true_lepton_angle, tx, ty);
			end else begin
				tx = lx;
				ty = ly;
			end
			dx = mx + lx;
			dy = my + ly;
			if (mode == MET_RESOL_UP || mode == MET_RESOL_DOWN) begin
				dx = dx - (gx + tx);
				dy = dy - (gy + ty);
			end
			minus = (mode == MET_RESP_DOWN || mode == MET_RESOL_DOWN);
			e.shifted_met_x = settle(mx, dx, minus);
			e.shifted_met_y = settle(my, dy, minus);
			pending.push_back(e);
			events++;
		endfunction

		function void check(input mrs_out_t r);
			mrs_out_t e;
			results++;
			if (pending.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.shifted_met_x !== e.shifted_met_x) begin
				$error("shifted_met_x expected %0d actual %0d", e.shifted_met_x, r.shifted_met_x);
				errors++;
			end
			if (r.shifted_met_y !== e.shifted_met_y) begin
				$error("shifted_met_y expected %0d actual %0d", e.shifted_met_y, r.shifted_met_y);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mrs_in_t data_in = '0;
	logic done;
	mrs_out_t data_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:2] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	met_shift_board board = new();
	bit steady;
	int quiet;
	int phases;

	met_recoil_shift u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .data_in(data_in),
		.done(done), .data_out(data_out), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				board.note(data_in);
			end
			if (done) begin
				board.check(data_out);
			end
			if ((start && !busy) || done) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
			end
			if (quiet > 3000) begin
				$display("met_recoil_shift regression: fail");
				$finish;
			end
		end
	end

	task automatic send(input mrs_in_t t);
		while (!steady && $urandom_range(0, 99) < 35) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		data_in = t;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic set_cfg(input logic [15:0] s, input logic [1:0] m);
		start = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		for (int i = 0; i < 2; i++) begin
			psel = 1'b1;
			pwrite = 1'b1;
			penable = 1'b0;
			paddr = (i == 0) ? ADDR_SCALE : ADDR_MODE;
			pwdata = (i == 0) ? {16'b0, s} : {30'b0, m};
			@(negedge clk);
			penable = 1'b1;
			do @(posedge clk); while (!pready);
			@(negedge clk);
			psel = 1'b0;
			penable = 1'b0;
		end
		board.scale = s;
		board.mode = m;
		phases++;
	endtask

	function automatic logic [15:0] pick_mag();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_ang();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;
			3: return 16'hC000 + 16'($urandom_range(0, 2)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mrs_in_t pick_event();
		mrs_in_t t;
		t.lepton_mag = pick_mag();
		t.lepton_angle = pick_ang();
		t.met_mag = pick_mag();
		t.met_angle = pick_ang();
		t.true_met_mag = pick_mag();
		t.true_met_angle = pick_ang();
		t.true_lepton_present = $urandom_range(0, 1);
		t.true_lepton_mag = pick_mag();
		t.true_lepton_angle = pick_ang();
		return t;
	endfunction

	logic [15:0] scales[7] = '{16'd6554, 16'd1, 16'hFFFF, 16'd0, 16'h8000, 16'd32767, 16'd300};

	initial begin
		mrs_in_t t;
		quiet = 0;
		steady = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int m = 0; m < 4; m++) begin
			set_cfg(m[0] ? 16'hFFFF : 16'd1, 2'(m));
			for (int k = 0; k < 6; k++) begin
				t = '0;
				t.true_lepton_present = k[0];
				if (k >= 2) begin
					t.lepton_mag = 16'hFFFF;
					t.met_mag = 16'hFFFF;
					t.true_met_mag = (k >= 4) ? 16'd0 : 16'hFFFF;
					t.true_lepton_mag = 16'hFFFF;
				end
				t.lepton_angle = (k >= 4) ? 16'h8000 : 16'h7FFF;
				t.met_angle = (k >= 4) ? 16'h7FFF : 16'h4000;
				t.true_met_angle = 16'hC000;
				t.true_lepton_angle = 16'h8000;
				send(t);
			end
		end

		for (int p = 0; p < 12; p++) begin
			set_cfg(scales[p % 7], 2'($urandom_range(0, 3)));
			steady = (p == 5);
			for (int n = 0; n < 50; n++) send(pick_event());
		end
		steady = 1'b0;

		start = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("Ran %0d events in %0d setting phases across all four shift modes.",
			board.events, phases);
		$display("Checked %0d results, %0d mismatches.", board.results, board.errors);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("met_recoil_shift regression: pass");
		end else begin
			$display("met_recoil_shift regression: fail");
		end
		$finish;
	end

endmodule
